/* design/axis_rotate_position_velocity_assert.svh */
// Assertion macros used by the rotator top level.
`ifndef AXIS_ROTATE_POSITION_VELOCITY_ASSERT_SVH
`define AXIS_ROTATE_POSITION_VELOCITY_ASSERT_SVH

`ifndef SYNTHESIS
`define ARPV_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("arpv assertion failed");
`define ARPV_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("arpv assertion failed");
`else
`define ARPV_ASSERT_IMPLY(name, clk, rstn, ante, cons)
`define ARPV_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

/* design/arpv_pkg.sv */
// Shared types, constants and tables of the position and velocity rotator.
`timescale 1ns / 1ps

package arpv_pkg;

    localparam int COORD_W      = 32;
    localparam int ANGLE_W      = 16;
    localparam int VEC_DIM      = 3;
    localparam int N_VEC        = 2;
    localparam int N_COMP       = VEC_DIM * N_VEC;
    localparam int DATA_W       = COORD_W * N_COMP;
    localparam int TDATA_W      = ((DATA_W + 7) / 8) * 8;

    // Binary angle: 2^BANG_W is one full turn.
    localparam int BANG_W       = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_IW      = $clog2(CORDIC_STEPS);
    localparam int COEF_W       = 32;
    localparam int COEF_FRAC    = 30;
    localparam int Z_W          = 32;
    localparam int PROD_W       = COEF_W + COORD_W;
    localparam int SUM_W        = PROD_W + 1;

    localparam int CFG_IDX_W    = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ANGLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_AXIS  = CFG_IDX_W'(1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    localparam coef_t  COEF_ONE    = coef_t'(1) <<< COEF_FRAC;
    localparam coef_t  CORDIC_GAIN = coef_t'(32'h26DD3B6A);
    localparam coord_t COORD_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

    // Arctangent of 2^-i in binary angle units; unused slots are zero.
    localparam logic [BANG_W-1:0] ATAN_TURNS [2**STEP_IW] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z,
        AXIS_NONE
    } axis_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    // Components from the lowest bits up: pos x, y, z, vel x, y, z.
    typedef struct packed {
        logic [N_COMP-1:0][COORD_W-1:0] comp;
        logic                           last;
    } body_t;

    typedef struct packed {
        coef_t                 x;
        coef_t                 y;
        logic signed [Z_W-1:0] z;
        quad_t                 quad;
        axis_t                 axis;
        body_t                 body;
    } chain_word_t;

endpackage

/* design/arpv_cordic_cell.sv */
// One CORDIC rotation step that carries the body word along with it.
`timescale 1ns / 1ps

module arpv_cordic_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [arpv_pkg::STEP_IW-1:0]  step,
    input  logic                          in_valid,
    input  arpv_pkg::chain_word_t         in_word,
    output logic                          out_valid,
    output arpv_pkg::chain_word_t         out_word
);

    logic                            valid_reg;
    logic                            valid_next;
    arpv_pkg::chain_word_t           word_reg;
    arpv_pkg::chain_word_t           word_next;
    arpv_pkg::coef_t                 dx;
    arpv_pkg::coef_t                 dy;
    logic signed [arpv_pkg::Z_W-1:0] turn;

    always_comb begin
        valid_next = in_valid;
        word_next  = in_word;
        // Arithmetic shifts round toward minus infinity.
        dx   = $signed(in_word.y) >>> step;
        dy   = $signed(in_word.x) >>> step;
        turn = $signed(arpv_pkg::Z_W'(arpv_pkg::ATAN_TURNS[step]));
        if (!in_word.z[arpv_pkg::Z_W-1]) begin
            word_next.x = in_word.x - dx;
            word_next.y = in_word.y + dy;
            word_next.z = in_word.z - turn;
        end else begin
            word_next.x = in_word.x + dx;
            word_next.y = in_word.y - dy;
            word_next.z = in_word.z + turn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* design/arpv_rotator.sv */
// Quadrant fold, coefficient products and rounded, saturated dot products.
`timescale 1ns / 1ps

module arpv_rotator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  arpv_pkg::chain_word_t in_word,
    output logic                  out_valid,
    output arpv_pkg::body_t       out_body
);

    // Stage A: coefficients and selected operands.
    logic                     a_valid_reg, a_valid_next;
    arpv_pkg::coef_t          a_c_reg, a_c_next;
    arpv_pkg::coef_t          a_k1_reg, a_k1_next;
    arpv_pkg::coef_t          a_k2_reg, a_k2_next;
    arpv_pkg::coord_t         a_va_reg [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         a_va_next [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         a_vb_reg [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         a_vb_next [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         a_vp_reg [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         a_vp_next [arpv_pkg::N_VEC];
    arpv_pkg::axis_t          a_axis_reg, a_axis_next;
    logic                     a_last_reg, a_last_next;

    // Stage B: products.
    logic                     b_valid_reg, b_valid_next;
    arpv_pkg::prod_t          b_pca_reg [arpv_pkg::N_VEC];
    arpv_pkg::prod_t          b_pca_next [arpv_pkg::N_VEC];
    arpv_pkg::prod_t          b_pkb_reg [arpv_pkg::N_VEC];
    arpv_pkg::prod_t          b_pkb_next [arpv_pkg::N_VEC];
    arpv_pkg::prod_t          b_pka_reg [arpv_pkg::N_VEC];
    arpv_pkg::prod_t          b_pka_next [arpv_pkg::N_VEC];
    arpv_pkg::prod_t          b_pcb_reg [arpv_pkg::N_VEC];
    arpv_pkg::prod_t          b_pcb_next [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         b_va_reg [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         b_vb_reg [arpv_pkg::N_VEC];
    arpv_pkg::coord_t         b_vp_reg [arpv_pkg::N_VEC];
    arpv_pkg::axis_t          b_axis_reg;
    logic                     b_last_reg;

    // Stage C: finished body.
    logic                     c_valid_reg, c_valid_next;
    arpv_pkg::body_t          c_body_reg, c_body_next;

    arpv_pkg::coef_t          cos_raw, sin_raw, cos_q, sin_q;
    logic [1:0]               ia, ib, ip;
    arpv_pkg::coord_t         r1, r2;

    function automatic arpv_pkg::coef_t clamp_unit(input arpv_pkg::coef_t v);
        if (v > arpv_pkg::COEF_ONE) begin
            return arpv_pkg::COEF_ONE;
        end else if (v < -arpv_pkg::COEF_ONE) begin
            return -arpv_pkg::COEF_ONE;
        end
        return v;
    endfunction

    // Rounds half toward plus infinity, then saturates to the coordinate range.
    function automatic arpv_pkg::coord_t round_sat(input arpv_pkg::prod_t p1,
                                                   input arpv_pkg::prod_t p2);
        logic signed [arpv_pkg::SUM_W-1:0] sum;
        logic signed [arpv_pkg::SUM_W-1:0] q;
        sum = {p1[arpv_pkg::PROD_W-1], p1} + {p2[arpv_pkg::PROD_W-1], p2}
            + (arpv_pkg::SUM_W'(1) << (arpv_pkg::COEF_FRAC - 1));
        q = sum >>> arpv_pkg::COEF_FRAC;
        if (q > arpv_pkg::SUM_W'(arpv_pkg::COORD_MAX)) begin
            return arpv_pkg::COORD_MAX;
        end else if (q < arpv_pkg::SUM_W'(arpv_pkg::COORD_MIN)) begin
            return arpv_pkg::COORD_MIN;
        end
        return q[arpv_pkg::COORD_W-1:0];
    endfunction

    always_comb begin
        case (in_word.quad)
            arpv_pkg::QUAD_1: begin
                cos_raw = -in_word.y;
                sin_raw = in_word.x;
            end
            arpv_pkg::QUAD_2: begin
                cos_raw = -in_word.x;
                sin_raw = -in_word.y;
            end
            arpv_pkg::QUAD_3: begin
                cos_raw = in_word.y;
                sin_raw = -in_word.x;
            end
            default: begin
                cos_raw = in_word.x;
                sin_raw = in_word.y;
            end
        endcase
        cos_q = clamp_unit(cos_raw);
        sin_q = clamp_unit(sin_raw);

        // ia and ib are the two rotated components, ip the one along the axis.
        case (in_word.axis)
            arpv_pkg::AXIS_X: begin
                ia = 2'd1;
                ib = 2'd2;
                ip = 2'd0;
                a_k1_next = sin_q;
            end
            arpv_pkg::AXIS_Y: begin
                ia = 2'd0;
                ib = 2'd2;
                ip = 2'd1;
                a_k1_next = -sin_q;
            end
            default: begin
                ia = 2'd0;
                ib = 2'd1;
                ip = 2'd2;
                a_k1_next = sin_q;
            end
        endcase
        a_k2_next   = -a_k1_next;
        a_c_next    = cos_q;
        a_valid_next = in_valid;
        a_axis_next = in_word.axis;
        a_last_next = in_word.body.last;
        for (int v = 0; v < arpv_pkg::N_VEC; v++) begin
            a_va_next[v] = in_word.body.comp[arpv_pkg::VEC_DIM * v + int'(ia)];
            a_vb_next[v] = in_word.body.comp[arpv_pkg::VEC_DIM * v + int'(ib)];
            a_vp_next[v] = in_word.body.comp[arpv_pkg::VEC_DIM * v + int'(ip)];
        end
    end

    always_comb begin
        b_valid_next = a_valid_reg;
        for (int v = 0; v < arpv_pkg::N_VEC; v++) begin
            b_pca_next[v] = arpv_pkg::PROD_W'(a_c_reg)  * arpv_pkg::PROD_W'(a_va_reg[v]);
            b_pkb_next[v] = arpv_pkg::PROD_W'(a_k1_reg) * arpv_pkg::PROD_W'(a_vb_reg[v]);
            b_pka_next[v] = arpv_pkg::PROD_W'(a_k2_reg) * arpv_pkg::PROD_W'(a_va_reg[v]);
            b_pcb_next[v] = arpv_pkg::PROD_W'(a_c_reg)  * arpv_pkg::PROD_W'(a_vb_reg[v]);
        end
    end

    always_comb begin
        c_valid_next     = b_valid_reg;
        c_body_next.last = b_last_reg;
        c_body_next.comp = '0;
        r1 = '0;
        r2 = '0;
        for (int v = 0; v < arpv_pkg::N_VEC; v++) begin
            r1 = round_sat(b_pca_reg[v], b_pkb_reg[v]);
            r2 = round_sat(b_pka_reg[v], b_pcb_reg[v]);
            case (b_axis_reg)
                arpv_pkg::AXIS_X: begin
                    c_body_next.comp[arpv_pkg::VEC_DIM * v]     = b_vp_reg[v];
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 1] = r1;
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 2] = r2;
                end
                arpv_pkg::AXIS_Y: begin
                    c_body_next.comp[arpv_pkg::VEC_DIM * v]     = r1;
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 1] = b_vp_reg[v];
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 2] = r2;
                end
                arpv_pkg::AXIS_Z: begin
                    c_body_next.comp[arpv_pkg::VEC_DIM * v]     = r1;
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 1] = r2;
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 2] = b_vp_reg[v];
                end
                default: begin
                    // No rotation: the original components pass straight through.
                    c_body_next.comp[arpv_pkg::VEC_DIM * v]     = b_va_reg[v];
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 1] = b_vb_reg[v];
                    c_body_next.comp[arpv_pkg::VEC_DIM * v + 2] = b_vp_reg[v];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_c_reg    <= a_c_next;
            a_k1_reg   <= a_k1_next;
            a_k2_reg   <= a_k2_next;
            a_axis_reg <= a_axis_next;
            a_last_reg <= a_last_next;
            b_axis_reg <= a_axis_reg;
            b_last_reg <= a_last_reg;
            c_body_reg <= c_body_next;
            for (int v = 0; v < arpv_pkg::N_VEC; v++) begin
                a_va_reg[v]  <= a_va_next[v];
                a_vb_reg[v]  <= a_vb_next[v];
                a_vp_reg[v]  <= a_vp_next[v];
                b_pca_reg[v] <= b_pca_next[v];
                b_pkb_reg[v] <= b_pkb_next[v];
                b_pka_reg[v] <= b_pka_next[v];
                b_pcb_reg[v] <= b_pcb_next[v];
                b_va_reg[v]  <= a_va_reg[v];
                b_vb_reg[v]  <= a_vb_reg[v];
                b_vp_reg[v]  <= a_vp_reg[v];
            end
        end
    end

    assign out_valid = c_valid_reg;
    assign out_body  = c_body_reg;

endmodule

/* design/axis_rotate_position_velocity.sv */
// Top level of the streaming position and velocity rotator.
`timescale 1ns / 1ps
`include "axis_rotate_position_velocity_assert.svh"

// Rotates each body's position and velocity vectors about the configured axis
// (0 x, 1 y, 2 z, 3 none) by the configured angle, a fraction of a full turn.
// Sine and cosine are produced per word by a chain of 30 CORDIC cells that the
// word travels through; eight 32 by 32 bit multipliers then form the rotated
// components, which are rounded and saturated. The block accepts one word
// every clock while the skid register is free. A word passes through 34
// registers (30 CORDIC cells, three rotation stages and the output register)
// on its way to the result port. An output register plus one skid register
// sit at the result side, so a stalled result stops the input only once the
// skid register holds a word. Configuration writes are taken at any time and
// must happen while no word is in flight.

module axis_rotate_position_velocity (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [arpv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arpv_pkg::ANGLE_W-1:0]     cfg_data,
    // Input words.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [arpv_pkg::TDATA_W-1:0]     s_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic                             s_tlast,  // last_in
    // Result words.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [arpv_pkg::TDATA_W-1:0]     m_tdata,  // rot_pos_x .. rot_pos_z, rot_vel_x .. rot_vel_z
    output logic                             m_tlast   // last_out
);

    logic [arpv_pkg::ANGLE_W-1:0] angle_reg, angle_next;
    arpv_pkg::axis_t              axis_reg, axis_next;

    logic                         en;
    logic [arpv_pkg::BANG_W-1:0]  bang;
    arpv_pkg::chain_word_t        chain_word [arpv_pkg::CORDIC_STEPS+1];
    logic                         chain_valid [arpv_pkg::CORDIC_STEPS+1];

    logic                         tail_valid;
    arpv_pkg::body_t              tail_body;

    logic                         out_valid_reg, out_valid_next;
    arpv_pkg::body_t              out_body_reg, out_body_next;
    logic                         skid_valid_reg, skid_valid_next;
    arpv_pkg::body_t              skid_body_reg, skid_body_next;
    logic                         out_take;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb begin
        angle_next = angle_reg;
        axis_next  = axis_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                arpv_pkg::REG_ROT_ANGLE: angle_next = cfg_data;
                arpv_pkg::REG_ROT_AXIS:  axis_next  = arpv_pkg::axis_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            axis_reg  <= arpv_pkg::AXIS_Z;
        end else begin
            angle_reg <= angle_next;
            axis_reg  <= axis_next;
        end
    end

    // The whole pipeline moves while the skid register is free.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // The top two angle bits pick the quadrant; the rest drive the CORDIC.
    always_comb begin
        bang = arpv_pkg::BANG_W'(angle_reg) << (arpv_pkg::BANG_W - arpv_pkg::ANGLE_W);
        chain_valid[0]          = s_tvalid;
        chain_word[0].x         = arpv_pkg::CORDIC_GAIN;
        chain_word[0].y         = '0;
        chain_word[0].z         = arpv_pkg::Z_W'(bang[arpv_pkg::BANG_W-3:0]);
        chain_word[0].quad      = arpv_pkg::quad_t'(bang[arpv_pkg::BANG_W-1 -: 2]);
        chain_word[0].axis      = axis_reg;
        chain_word[0].body.comp = s_tdata[arpv_pkg::DATA_W-1:0];
        chain_word[0].body.last = s_tlast;
    end

    for (genvar gi = 0; gi < arpv_pkg::CORDIC_STEPS; gi++) begin : g_cell
        arpv_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step      (arpv_pkg::STEP_IW'(gi)),
            .in_valid  (chain_valid[gi]),
            .in_word   (chain_word[gi]),
            .out_valid (chain_valid[gi+1]),
            .out_word  (chain_word[gi+1])
        );
    end

    arpv_rotator u_rotator (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_valid[arpv_pkg::CORDIC_STEPS]),
        .in_word   (chain_word[arpv_pkg::CORDIC_STEPS]),
        .out_valid (tail_valid),
        .out_body  (tail_body)
    );

    // Output register with one skid entry behind it.
    assign out_take = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_body_next   = out_body_reg;
        skid_valid_next = skid_valid_reg;
        skid_body_next  = skid_body_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_body_next   = skid_body_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || out_take) begin
            out_valid_next = tail_valid;
            out_body_next  = tail_body;
        end else if (tail_valid) begin
            skid_valid_next = 1'b1;
            skid_body_next  = tail_body;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_body_reg  <= out_body_next;
        skid_body_reg <= skid_body_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = arpv_pkg::TDATA_W'(out_body_reg.comp);
    assign m_tlast  = out_body_reg.last;

    `ARPV_ASSERT_IMPLY(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_tvalid)
    `ARPV_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, (!skid_valid_reg && m_tvalid && !m_tready && tail_valid), skid_valid_reg)
    `ARPV_ASSERT_NEXT(a_skid_holds, aclk, aresetn, (skid_valid_reg && !m_tready), (skid_valid_reg && $stable(skid_body_reg)))

endmodule
